[src/vref_pkg.sv]
// shared types and constants for the vector refraction pipeline
package vref_pkg;

   // field widths of one item and one result
   localparam int IN_W = 16;
   localparam int OUT_W = 20;

   // default number of fraction bits
   localparam int FRAC_BITS_DEF = 14;

   typedef struct packed {
      logic signed [IN_W-1:0] inc_x;
      logic signed [IN_W-1:0] inc_y;
      logic signed [IN_W-1:0] inc_z;
      logic signed [IN_W-1:0] nrm_x;
      logic signed [IN_W-1:0] nrm_y;
      logic signed [IN_W-1:0] nrm_z;
      logic [IN_W-1:0] ior_ratio;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] ref_x;
      logic signed [OUT_W-1:0] ref_y;
      logic signed [OUT_W-1:0] ref_z;
      logic valid_res;
   } rsp_type;

   // larger of two elaboration-time widths
   function automatic int vmax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

[src/vector_refraction.sv]
// vector refraction top level: Snell refraction of a direction in fixed point
//
// Takes one item per clock: busy is high only while reset is held, so every
// cycle with start high outside reset enters an item. Each item comes out on
// rsp_item with rsp_strobe high for one cycle, in order; the receiver must take
// it in that cycle. Each item passes through the square root, a pipeline that
// resolves one root bit per stage, plus ten stages of dot product, squaring,
// scaling and the final multiply-add. All work is stateless and there is no
// start-up sweep after reset. When k is negative (total internal reflection)
// valid_res is low and the vector is zero.
module vector_refraction #(
   parameter int FRAC_BITS = vref_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  vref_pkg::req_type req_item,
   output logic rsp_strobe,
   output vref_pkg::rsp_type rsp_item
);

   localparam int IN_W = vref_pkg::IN_W;
   localparam int OUT_W = vref_pkg::OUT_W;
   // dot product of two vectors, negated without overflow
   localparam int DOT_W = 2 * IN_W + 2;
   localparam int CI_W = DOT_W - FRAC_BITS;
   localparam int CI2_W = 2 * CI_W;
   localparam int U_W = vref_pkg::vmax(CI2_W - FRAC_BITS, FRAC_BITS + 1) + 1;
   localparam int E2_W = 2 * IN_W - FRAC_BITS;
   localparam int P_W = E2_W + 1 + U_W;
   localparam int K_W = vref_pkg::vmax(P_W - FRAC_BITS, FRAC_BITS + 2) + 1;
   // radicand k << F, padded to an even width for the two-bit root steps
   localparam int R_W = K_W - 1 + FRAC_BITS;
   localparam int RAD_W = R_W + (R_W % 2);
   localparam int SQ_W = RAD_W / 2;
   localparam int EC_W = IN_W + 1 + CI_W;
   localparam int ECS_W = EC_W - FRAC_BITS;
   localparam int S_W = vref_pkg::vmax(ECS_W, SQ_W + 1) + 1;
   localparam int A_W = 2 * IN_W + 1;
   localparam int B_W = S_W + IN_W;
   localparam int SUM_W = vref_pkg::vmax(vref_pkg::vmax(A_W, B_W), OUT_W + FRAC_BITS) + 1;
   localparam int SH_W = SUM_W - FRAC_BITS;
   localparam int LAT = SQ_W + 10;

   localparam logic signed [U_W-1:0] ONE_U = U_W'(1 << FRAC_BITS);
   localparam logic signed [K_W-1:0] ONE_K = K_W'(1 << FRAC_BITS);
   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(1 << (OUT_W - 1)));

   // side data that rides along the root pipeline
   typedef struct packed {
      logic tir;
      logic signed [ECS_W-1:0] ecs;
      vref_pkg::req_type item;
   } side_type;

   function automatic logic signed [OUT_W-1:0] sat_fn(input logic signed [SH_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   // the pipeline never stalls, items are refused only during reset
   assign busy = reset;

   // stage 1: input register
   logic s1_vld_ff;
   vref_pkg::req_type s1_item_ff;

   // stage 2: per-axis products and eta squared
   logic s2_vld_ff;
   vref_pkg::req_type s2_item_ff;
   logic signed [2*IN_W-1:0] dpx_ff, dpy_ff, dpz_ff;
   logic [2*IN_W-1:0] e2f_ff;
   logic signed [2*IN_W-1:0] dpx_in, dpy_in, dpz_in;
   logic [2*IN_W-1:0] e2f_in;

   // stage 3: ci = floor(-d / 2^F) and e2
   logic s3_vld_ff;
   vref_pkg::req_type s3_item_ff;
   logic signed [CI_W-1:0] ci_ff;
   logic [E2_W-1:0] e2_s3_ff;
   logic signed [DOT_W-1:0] dsum, negd;

   // stage 4: ci squared and eta*ci
   logic s4_vld_ff;
   vref_pkg::req_type s4_item_ff;
   logic signed [CI2_W-1:0] ci2_ff;
   logic signed [EC_W-1:0] ec_ff;
   logic [E2_W-1:0] e2_s4_ff;
   logic signed [CI2_W-1:0] ci2_in;
   logic signed [EC_W-1:0] ec_in;

   // stage 5: u = 1 - ci^2
   logic s5_vld_ff;
   vref_pkg::req_type s5_item_ff;
   logic signed [U_W-1:0] u_ff;
   logic signed [ECS_W-1:0] ecs_s5_ff;
   logic [E2_W-1:0] e2_s5_ff;

   // stage 6: e2*u
   logic s6_vld_ff;
   vref_pkg::req_type s6_item_ff;
   logic signed [P_W-1:0] pr_ff;
   logic signed [ECS_W-1:0] ecs_s6_ff;
   logic signed [P_W-1:0] pr_in;

   // stage 7: k and the radicand
   logic s7_vld_ff;
   side_type s7_side_ff;
   logic [RAD_W-1:0] rad_ff;
   logic signed [K_W-1:0] kv;

   // root pipeline and its side line
   logic sq_vld;
   logic [SQ_W-1:0] sq_root;
   side_type sd_ff [SQ_W];

   // stage 8: s = floor(eta*ci / 2^F) - sqrt(k)
   logic s8_vld_ff;
   logic s8_tir_ff;
   vref_pkg::req_type s8_item_ff;
   logic signed [S_W-1:0] s_ff;

   // stage 9: eta*i and s*n per lane
   logic s9_vld_ff;
   logic s9_tir_ff;
   logic signed [A_W-1:0] a_ff [3];
   logic signed [B_W-1:0] b_ff [3];
   logic signed [A_W-1:0] a_in [3];
   logic signed [B_W-1:0] b_in [3];
   logic signed [IN_W-1:0] inc_v [3];
   logic signed [IN_W-1:0] nrm_v [3];

   // stage 10: output register
   logic rsp_strobe_ff;
   vref_pkg::rsp_type rsp_item_ff;
   vref_pkg::rsp_type rsp_item_in;
   logic signed [SUM_W-1:0] sum_v [3];
   logic signed [OUT_W-1:0] out_v [3];

   // valid bits for every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
         s9_vld_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= sq_vld;
         s9_vld_ff <= s8_vld_ff;
         rsp_strobe_ff <= s9_vld_ff;
      end
   end

   // stage 2 products
   always_comb begin
      dpx_in = s1_item_ff.inc_x * s1_item_ff.nrm_x;
      dpy_in = s1_item_ff.inc_y * s1_item_ff.nrm_y;
      dpz_in = s1_item_ff.inc_z * s1_item_ff.nrm_z;
      e2f_in = s1_item_ff.ior_ratio * s1_item_ff.ior_ratio;
   end

   // stage 3: full-width dot, negate, floor shift
   always_comb begin
      dsum = DOT_W'(dpx_ff) + DOT_W'(dpy_ff) + DOT_W'(dpz_ff);
      negd = -dsum;
   end

   // stage 4 products, eta zero-extended to stay positive
   always_comb begin
      ci2_in = CI2_W'(ci_ff) * CI2_W'(ci_ff);
      ec_in = EC_W'($signed({1'b0, s3_item_ff.ior_ratio})) * EC_W'(ci_ff);
   end

   // stage 6 product
   assign pr_in = P_W'($signed({1'b0, e2_s5_ff})) * P_W'(u_ff);

   // stage 7: k = 1 - floor(e2*u / 2^F)
   assign kv = ONE_K - K_W'($signed(pr_ff[P_W-1:FRAC_BITS]));

   always_ff @(posedge clock) begin
      s1_item_ff <= req_item;

      s2_item_ff <= s1_item_ff;
      dpx_ff <= dpx_in;
      dpy_ff <= dpy_in;
      dpz_ff <= dpz_in;
      e2f_ff <= e2f_in;

      s3_item_ff <= s2_item_ff;
      ci_ff <= $signed(negd[DOT_W-1:FRAC_BITS]);
      e2_s3_ff <= e2f_ff[2*IN_W-1:FRAC_BITS];

      s4_item_ff <= s3_item_ff;
      ci2_ff <= ci2_in;
      ec_ff <= ec_in;
      e2_s4_ff <= e2_s3_ff;

      s5_item_ff <= s4_item_ff;
      u_ff <= ONE_U - U_W'({1'b0, ci2_ff[CI2_W-1:FRAC_BITS]});
      ecs_s5_ff <= $signed(ec_ff[EC_W-1:FRAC_BITS]);
      e2_s5_ff <= e2_s4_ff;

      s6_item_ff <= s5_item_ff;
      pr_ff <= pr_in;
      ecs_s6_ff <= ecs_s5_ff;

      s7_side_ff.tir <= kv[K_W-1];
      s7_side_ff.ecs <= ecs_s6_ff;
      s7_side_ff.item <= s6_item_ff;
      // a negative k gives a meaningless root, masked at the output
      rad_ff <= RAD_W'({kv[K_W-2:0], {FRAC_BITS{1'b0}}});
   end

   vref_isqrt #(
      .RAD_W(RAD_W)
   ) u_isqrt (
      .clock(clock),
      .reset(reset),
      .in_valid(s7_vld_ff),
      .in_rad(rad_ff),
      .out_valid(sq_vld),
      .out_root(sq_root)
   );

   // side line, one entry per root stage
   always_ff @(posedge clock) begin
      sd_ff[0] <= s7_side_ff;
      for (int j = 1; j < SQ_W; j++) begin
         sd_ff[j] <= sd_ff[j-1];
      end
   end

   // stage 8
   always_ff @(posedge clock) begin
      s8_tir_ff <= sd_ff[SQ_W-1].tir;
      s8_item_ff <= sd_ff[SQ_W-1].item;
      s_ff <= S_W'(sd_ff[SQ_W-1].ecs) - S_W'({1'b0, sq_root});
   end

   // stage 9 lanes
   always_comb begin
      inc_v[0] = s8_item_ff.inc_x;
      inc_v[1] = s8_item_ff.inc_y;
      inc_v[2] = s8_item_ff.inc_z;
      nrm_v[0] = s8_item_ff.nrm_x;
      nrm_v[1] = s8_item_ff.nrm_y;
      nrm_v[2] = s8_item_ff.nrm_z;
      for (int j = 0; j < 3; j++) begin
         a_in[j] = A_W'($signed({1'b0, s8_item_ff.ior_ratio})) * A_W'(inc_v[j]);
         b_in[j] = B_W'(s_ff) * B_W'(nrm_v[j]);
      end
   end

   always_ff @(posedge clock) begin
      s9_tir_ff <= s8_tir_ff;
      for (int j = 0; j < 3; j++) begin
         a_ff[j] <= a_in[j];
         b_ff[j] <= b_in[j];
      end
   end

   // stage 10: add, floor shift, clamp, zero on total internal reflection
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum_v[j] = SUM_W'(a_ff[j]) + SUM_W'(b_ff[j]);
         out_v[j] = s9_tir_ff ? '0 : sat_fn($signed(sum_v[j][SUM_W-1:FRAC_BITS]));
      end
      rsp_item_in.ref_x = out_v[0];
      rsp_item_in.ref_y = out_v[1];
      rsp_item_in.ref_z = out_v[2];
      rsp_item_in.valid_res = !s9_tir_ff;
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

   // every accepted item comes out after the fixed latency
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_strobe)
      else $error("item accepted but no result after pipeline latency");

   // no result appears without an item taken the same latency earlier
   a_latency_bwd : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result strobe without a matching accepted item");

   // total internal reflection gives a zero vector
   a_tir_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.valid_res |->
         rsp_item.ref_x == '0 && rsp_item.ref_y == '0 && rsp_item.ref_z == '0)
      else $error("invalid result carries a nonzero vector");

endmodule

[src/vref_isqrt.sv]
// pipelined floor square root, one root bit per register stage
module vref_isqrt #(
   parameter int RAD_W = 46
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [RAD_W-1:0] in_rad,
   output logic out_valid,
   output logic [RAD_W/2-1:0] out_root
);

   localparam int ROOT_W = RAD_W / 2;

   logic vld_ff [ROOT_W];
   logic [ROOT_W+1:0] rem_ff [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0] rad_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      logic vld_prev;
      logic [ROOT_W+1:0] rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0] rad_prev;
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      logic [ROOT_W+1:0] rem_in;
      logic bit_in;

      if (j == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign root_prev = '0;
         assign rad_prev = in_rad;
      end else begin : g_next
         assign vld_prev = vld_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rad_prev = rad_ff[j-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign rem_sh = {rem_prev[ROOT_W-1:0], rad_prev[RAD_W-1 -: 2]};
      assign trial = {root_prev, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            bit_in = 1'b1;
         end else begin
            rem_in = rem_sh;
            bit_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         root_ff[j] <= {root_prev[ROOT_W-2:0], bit_in};
         rad_ff[j] <= {rad_prev[RAD_W-3:0], 2'b00};
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];

endmodule
